FILE: hdl/x10_rf_pulse_interval_decoder_core_assert.svh
// Assertion macros used by the pulse interval decoder checker.
`ifndef X10_RF_PULSE_INTERVAL_DECODER_CORE_ASSERT_SVH
`define X10_RF_PULSE_INTERVAL_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define X10RF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("x10rf check failed");

// Next-cycle implication, held off while reset is asserted.
`define X10RF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("x10rf check failed");

`endif

FILE: hdl/x10rf_pkg.sv
// Shared constants, types and helper functions of the pulse interval decoder.
`default_nettype none

package x10rf_pkg;

    // Frame and datapath widths
    localparam int FRAME_BITS = 32;
    localparam int TIME_W     = 32;
    localparam int WIN_W      = 20;
    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = $clog2(WORD_W);
    localparam int POS_W      = $clog2(FRAME_BITS + 1);

    // Configuration port geometry
    localparam int REG_COUNT = 7;
    localparam int SEL_W     = $clog2(REG_COUNT);
    localparam int ADDR_W    = SEL_W + 2;
    localparam int DATA_W    = 32;

    // Register indexes
    localparam logic [SEL_W-1:0] REG_START_REPEAT_MIN = SEL_W'(0);
    localparam logic [SEL_W-1:0] REG_START_MAX        = SEL_W'(1);
    localparam logic [SEL_W-1:0] REG_START_ARM_MIN    = SEL_W'(2);
    localparam logic [SEL_W-1:0] REG_ONE_MIN          = SEL_W'(3);
    localparam logic [SEL_W-1:0] REG_ONE_MAX          = SEL_W'(4);
    localparam logic [SEL_W-1:0] REG_ZERO_MIN         = SEL_W'(5);
    localparam logic [SEL_W-1:0] REG_ZERO_MAX         = SEL_W'(6);

    // Register reset values, microseconds
    localparam logic [WIN_W-1:0] START_REPEAT_MIN_RST = WIN_W'(7000);
    localparam logic [WIN_W-1:0] START_MAX_RST        = WIN_W'(15000);
    localparam logic [WIN_W-1:0] START_ARM_MIN_RST    = WIN_W'(12000);
    localparam logic [WIN_W-1:0] ONE_MIN_RST          = WIN_W'(2000);
    localparam logic [WIN_W-1:0] ONE_MAX_RST          = WIN_W'(2600);
    localparam logic [WIN_W-1:0] ZERO_MIN_RST         = WIN_W'(1000);
    localparam logic [WIN_W-1:0] ZERO_MAX_RST         = WIN_W'(1400);

    // Result kinds
    localparam logic KIND_STANDARD = 1'b0;
    localparam logic KIND_SECURITY = 1'b1;

    // Security code signature
    localparam logic [BYTE_W-1:0] SEC_LOW_XOR  = 8'h0F;
    localparam logic [BYTE_W-1:0] SEC_HIGH_XOR = 8'hFF;

    typedef struct packed {
        logic [WIN_W-1:0] start_repeat_min;
        logic [WIN_W-1:0] start_max;
        logic [WIN_W-1:0] start_arm_min;
        logic [WIN_W-1:0] one_min;
        logic [WIN_W-1:0] one_max;
        logic [WIN_W-1:0] zero_min;
        logic [WIN_W-1:0] zero_max;
    } x10rf_win_t;

    // Mirror the bit order of one byte
    function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    // Inclusive window test; min above max matches nothing
    function automatic logic in_window(input logic [TIME_W-1:0] x,
                                       input logic [WIN_W-1:0]  lo,
                                       input logic [WIN_W-1:0]  hi);
        logic [TIME_W-1:0] lo_ext;
        logic [TIME_W-1:0] hi_ext;
        lo_ext = {{(TIME_W-WIN_W){1'b0}}, lo};
        hi_ext = {{(TIME_W-WIN_W){1'b0}}, hi};
        return (x >= lo_ext) && (x <= hi_ext);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/x10_rf_pulse_interval_decoder_core.sv
// Top level of the X10 RF pulse interval decoder.
`default_nettype none

// Takes one rising-edge timestamp word per cycle while in_ready is high and decodes X10 RF
// pulse-distance frames: the interval since the previous edge is matched against the start,
// one and zero windows held in seven APB registers (register i at byte address 4*i), and a
// 32-bit frame that passes the standard or security code check yields one result word. An
// edge word is held in the input register, is decoded by a single stage of window compares
// and shift-word update, and lands in the result register; edges stream at one per cycle
// while results are taken. The result register lets one more edge be taken while a result
// waits.

module x10_rf_pulse_interval_decoder_core
    import x10rf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [TIME_W-1:0] edge_time_us,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   code_kind,
    output logic      [BYTE_W-1:0] byte_zero,
    output logic      [BYTE_W-1:0] byte_one,
    output logic      [BYTE_W-1:0] byte_two,
    output logic      [BYTE_W-1:0] byte_three
);

    x10rf_win_t win;

    // Control and frame state
    logic              stage_valid_reg;
    logic              stage_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] last_time_next;
    logic [WORD_W-1:0] shift_reg;
    logic [WORD_W-1:0] shift_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;

    // Payload registers
    logic [TIME_W-1:0] time_reg;
    logic              kind_reg;
    logic [BYTE_W-1:0] b0_reg;
    logic [BYTE_W-1:0] b1_reg;
    logic [BYTE_W-1:0] b2_reg;
    logic [BYTE_W-1:0] b3_reg;

    // Decode stage
    logic              in_fire;
    logic              advance;
    logic              fire;
    logic [TIME_W-1:0] len;
    logic              is_start;
    logic              is_arm;
    logic              is_one;
    logic              is_zero;
    logic [IDX_W-1:0]  bit_idx;
    logic [POS_W-1:0]  pos_dec;
    logic [WORD_W-1:0] word;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic              is_standard;
    logic              is_security;
    logic              emit;

    x10rf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .win     (win)
    );

    // Handshake: the stage moves whenever the result register is free or drains
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = stage_valid_reg && advance;
    assign in_ready = !stage_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // Classify the interval
    assign len      = time_reg - last_time_reg;
    assign is_start = in_window(len, win.start_repeat_min, win.start_max);
    assign is_arm   = len >= {{(TIME_W-WIN_W){1'b0}}, win.start_arm_min};
    assign is_one   = in_window(len, win.one_min, win.one_max);
    assign is_zero  = in_window(len, win.zero_min, win.zero_max);

    // Bit slot of the current position
    assign pos_dec = pos_reg - POS_W'(1);
    assign bit_idx = IDX_W'(pos_dec);
    assign word    = is_one ? (shift_reg | (WORD_W'(1) << bit_idx)) : shift_reg;

    // Bit-reverse the bytes and check both code forms
    assign b0 = rev8(word[BYTE_W-1:0]);
    assign b1 = rev8(word[2*BYTE_W-1:BYTE_W]);
    assign b2 = rev8(word[3*BYTE_W-1:2*BYTE_W]);
    assign b3 = rev8(word[4*BYTE_W-1:3*BYTE_W]);
    assign is_security = ((b1 ^ b0) == SEC_LOW_XOR) && ((b3 ^ b2) == SEC_HIGH_XOR);
    assign is_standard = ((b1 & b0) == '0) && ((b3 & b2) == '0);

    // Next frame state
    always_comb
    begin
        shift_next = shift_reg;
        pos_next   = pos_reg;
        emit       = 1'b0;
        if (is_start)
        begin
            shift_next = '0;
            if (is_arm)
            begin
                pos_next = POS_W'(1);
            end
        end
        else if (pos_reg != '0)
        begin
            if (!is_one && !is_zero)
            begin
                pos_next = '0;
            end
            else
            begin
                shift_next = word;
                if (pos_reg >= POS_W'(FRAME_BITS))
                begin
                    pos_next = '0;
                    emit     = is_standard || is_security;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    assign last_time_next   = time_reg;
    assign stage_valid_next = in_fire ? 1'b1 : (fire ? 1'b0 : stage_valid_reg);
    assign out_valid_next   = advance ? (fire && emit) : out_valid_reg;

    // Control state and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_time_reg   <= '0;
            shift_reg       <= '0;
            pos_reg         <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (fire)
            begin
                last_time_reg <= last_time_next;
                shift_reg     <= shift_next;
                pos_reg       <= pos_next;
            end
        end
    end

    // Capture the edge word and the result word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            time_reg <= edge_time_us;
        end
        if (fire && emit)
        begin
            kind_reg <= is_standard ? KIND_STANDARD : KIND_SECURITY;
            b0_reg   <= b0;
            b1_reg   <= b1;
            b2_reg   <= b2;
            b3_reg   <= b3;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_kind  = kind_reg;
    assign byte_zero  = b0_reg;
    assign byte_one   = b1_reg;
    assign byte_two   = b2_reg;
    assign byte_three = b3_reg;

endmodule

`default_nettype wire

FILE: hdl/x10rf_regs.sv
// APB register file holding the interval windows of the decoder.
`default_nettype none

module x10rf_regs
    import x10rf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output x10rf_win_t             win
);

    x10rf_win_t       win_reg;
    x10rf_win_t       win_next;
    logic             wr_en;
    logic [SEL_W-1:0] sel;
    logic [WIN_W-1:0] wr_val;
    logic [WIN_W-1:0] rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = paddr[ADDR_W-1:2];
    assign wr_val = pwdata[WIN_W-1:0];

    // Decode the write
    always_comb
    begin
        win_next = win_reg;
        if (wr_en)
        begin
            unique case (sel)
                REG_START_REPEAT_MIN: win_next.start_repeat_min = wr_val;
                REG_START_MAX:        win_next.start_max        = wr_val;
                REG_START_ARM_MIN:    win_next.start_arm_min    = wr_val;
                REG_ONE_MIN:          win_next.one_min          = wr_val;
                REG_ONE_MAX:          win_next.one_max          = wr_val;
                REG_ZERO_MIN:         win_next.zero_min         = wr_val;
                REG_ZERO_MAX:         win_next.zero_max         = wr_val;
                default:              win_next = win_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.start_repeat_min <= START_REPEAT_MIN_RST;
            win_reg.start_max        <= START_MAX_RST;
            win_reg.start_arm_min    <= START_ARM_MIN_RST;
            win_reg.one_min          <= ONE_MIN_RST;
            win_reg.one_max          <= ONE_MAX_RST;
            win_reg.zero_min         <= ZERO_MIN_RST;
            win_reg.zero_max         <= ZERO_MAX_RST;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (sel)
            REG_START_REPEAT_MIN: rd_val = win_reg.start_repeat_min;
            REG_START_MAX:        rd_val = win_reg.start_max;
            REG_START_ARM_MIN:    rd_val = win_reg.start_arm_min;
            REG_ONE_MIN:          rd_val = win_reg.one_min;
            REG_ONE_MAX:          rd_val = win_reg.one_max;
            REG_ZERO_MIN:         rd_val = win_reg.zero_min;
            REG_ZERO_MAX:         rd_val = win_reg.zero_max;
            default:              rd_val = '0;
        endcase
    end

    assign prdata = {{(DATA_W-WIN_W){1'b0}}, rd_val};
    assign win    = win_reg;

endmodule

`default_nettype wire

FILE: hdl/x10rf_checker.sv
// Port-level checker of the pulse interval decoder and its bind.
`default_nettype none

`include "x10_rf_pulse_interval_decoder_core_assert.svh"

module x10rf_checker
    import x10rf_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              code_kind,
    input wire logic [BYTE_W-1:0] byte_zero,
    input wire logic [BYTE_W-1:0] byte_one,
    input wire logic [BYTE_W-1:0] byte_two,
    input wire logic [BYTE_W-1:0] byte_three
);

    logic [4*BYTE_W:0] out_word;
    logic              stalled;
    logic              std_out;
    logic              sec_out;
    logic              std_shape;
    logic              sec_sig;

    // Gather the result word and its code checks
    assign out_word  = {code_kind, byte_three, byte_two, byte_one, byte_zero};
    assign stalled   = out_valid && !out_ready;
    assign std_out   = out_valid && (code_kind == KIND_STANDARD);
    assign sec_out   = out_valid && (code_kind == KIND_SECURITY);
    assign std_shape = ((byte_one & byte_zero) == '0) && ((byte_three & byte_two) == '0);
    assign sec_sig   = ((byte_one ^ byte_zero) == SEC_LOW_XOR) &&
                       ((byte_three ^ byte_two) == SEC_HIGH_XOR);

    // A stalled result word holds
    `X10RF_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(out_word))

    // The register port never waits
    `X10RF_ASSERT_IMPLIES(a_pready_high, clk, rst_n, psel && penable, pready)

    // A standard word has no overlapping bits in either byte pair
    `X10RF_ASSERT_IMPLIES(a_standard_form, clk, rst_n, std_out, std_shape)

    // A security word carries its signature and fails the standard check
    `X10RF_ASSERT_IMPLIES(a_security_form, clk, rst_n, sec_out, sec_sig && !std_shape)

endmodule

bind x10_rf_pulse_interval_decoder_core x10rf_checker u_checker (.*);

`default_nettype wire

FILE: tb/sv/x10_rf_pulse_interval_decoder_core_tb.sv
// Self-checking testbench for the X10 RF pulse interval decoder core.
module x10_rf_pulse_interval_decoder_core_tb;
    import x10rf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PAD_W         = DATA_W - WIN_W;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
    } code_word_t;

    typedef enum int {
        WIN_RESET,
        WIN_LOW_EDGE,
        WIN_HIGH_EDGE,
        WIN_OVERLAP,
        WIN_BROKEN
    } window_preset_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [TIME_W-1:0] edge_time_us = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              code_kind;
    logic [BYTE_W-1:0] byte_zero;
    logic [BYTE_W-1:0] byte_one;
    logic [BYTE_W-1:0] byte_two;
    logic [BYTE_W-1:0] byte_three;

    // Decoder copy: window settings and receive state
    x10rf_win_t        win_model;
    logic [TIME_W-1:0] prev_stamp = '0;
    logic [WORD_W-1:0] frame_bits = '0;
    logic [5:0]        bit_pos = '0;

    logic [TIME_W-1:0] edge_queue[$];
    code_word_t        pending_codes[$];
    logic [TIME_W-1:0] gen_stamp = '0;
    int                queued_count = 0;
    int                accepted_count = 0;
    int                result_count = 0;
    int                frame_items = 0;
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;

    x10_rf_pulse_interval_decoder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .edge_time_us (edge_time_us),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code_kind    (code_kind),
        .byte_zero    (byte_zero),
        .byte_one     (byte_one),
        .byte_two     (byte_two),
        .byte_three   (byte_three)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] got,
                               input logic [BYTE_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    function automatic logic [BYTE_W-1:0] mirror_byte(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[BYTE_W-1-i] = v[i];
        end
        return r;
    endfunction

    // Inclusive interval test; an inverted span holds nothing
    function automatic logic in_span(input logic [TIME_W-1:0] x, input logic [WIN_W-1:0] lo,
                                     input logic [WIN_W-1:0] hi);
        return (x >= TIME_W'(lo)) && (x <= TIME_W'(hi));
    endfunction

    // Advance the decoder copy by one edge; flag a code word when a frame passes
    task automatic decode_edge(input logic [TIME_W-1:0] stamp_in, output bit produced,
                               output code_word_t word);
        logic [TIME_W-1:0] span;
        logic [BYTE_W-1:0] c0, c1, c2, c3;
        logic              is_one;
        logic              is_std, is_sec;
        produced = 1'b0;
        word = '0;
        span = stamp_in - prev_stamp;
        prev_stamp = stamp_in;
        is_one = in_span(span, win_model.one_min, win_model.one_max);
        if (in_span(span, win_model.start_repeat_min, win_model.start_max))
        begin
            frame_bits = '0;
            if (span >= TIME_W'(win_model.start_arm_min))
            begin
                bit_pos = 6'd1;
            end
        end
        else if (bit_pos != 6'd0)
        begin
            if (is_one)
            begin
                frame_bits[IDX_W'(bit_pos - 6'd1)] = 1'b1;
            end
            if (!is_one && !in_span(span, win_model.zero_min, win_model.zero_max))
            begin
                bit_pos = 6'd0;
            end
            else if (bit_pos >= 6'(FRAME_BITS))
            begin
                c0 = mirror_byte(frame_bits[7:0]);
                c1 = mirror_byte(frame_bits[15:8]);
                c2 = mirror_byte(frame_bits[23:16]);
                c3 = mirror_byte(frame_bits[31:24]);
                is_std = ((c1 & c0) == '0) && ((c3 & c2) == '0);
                is_sec = ((c1 ^ c0) == SEC_LOW_XOR) && ((c3 ^ c2) == SEC_HIGH_XOR);
                bit_pos = 6'd0;
                if (is_std || is_sec)
                begin
                    produced = 1'b1;
                    word.kind = is_std ? KIND_STANDARD : KIND_SECURITY;
                    word.b0 = c0;
                    word.b1 = c1;
                    word.b2 = c2;
                    word.b3 = c3;
                end
            end
            else
            begin
                bit_pos = bit_pos + 6'd1;
            end
        end
    endtask

    // Driver: hold the word until taken, then offer the next one or idle
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (edge_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                edge_time_us <= edge_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result word, then predict from each accepted edge
    always @(posedge clk)
    begin
        code_word_t want;
        code_word_t fresh;
        bit         hit;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (pending_codes.size() == 0)
                begin
                    report_mismatch("result word with nothing expected");
                end
                else
                begin
                    want = pending_codes.pop_front();
                    check_field("code_kind", 8'(code_kind), 8'(want.kind));
                    check_field("byte_zero", byte_zero, want.b0);
                    check_field("byte_one", byte_one, want.b1);
                    check_field("byte_two", byte_two, want.b2);
                    check_field("byte_three", byte_three, want.b3);
                end
            end
            if (in_valid && in_ready)
            begin
                accepted_count++;
                decode_edge(edge_time_us, hit, fresh);
                if (hit)
                begin
                    pending_codes.push_back(fresh);
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Write one register over APB, update the copy, then read it back
    task automatic write_reg(input logic [SEL_W-1:0] idx, input logic [WIN_W-1:0] value);
        logic [DATA_W-1:0] seen;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {PAD_W'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_START_REPEAT_MIN: win_model.start_repeat_min = value;
            REG_START_MAX:        win_model.start_max = value;
            REG_START_ARM_MIN:    win_model.start_arm_min = value;
            REG_ONE_MIN:          win_model.one_min = value;
            REG_ONE_MAX:          win_model.one_max = value;
            REG_ZERO_MIN:         win_model.zero_min = value;
            REG_ZERO_MAX:         win_model.zero_max = value;
            default:              ;
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        seen = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (seen[WIN_W-1:0] !== value)
        begin
            report_mismatch($sformatf("register %0d reads %0h want %0h", idx,
                                      seen[WIN_W-1:0], value));
        end
    endtask

    function automatic x10rf_win_t preset_windows(input window_preset_t which);
        x10rf_win_t w;
        case (which)
            WIN_LOW_EDGE:
            begin
                w.zero_min = '0;
                w.zero_max = '0;
                w.one_min = WIN_W'(1);
                w.one_max = WIN_W'(1);
                w.start_repeat_min = WIN_W'(2);
                w.start_arm_min = WIN_W'(3);
                w.start_max = WIN_W'(3);
            end
            WIN_HIGH_EDGE:
            begin
                w.zero_min = WIN_W'(20'hFFFF0);
                w.zero_max = WIN_W'(20'hFFFF5);
                w.one_min = WIN_W'(20'hFFFF6);
                w.one_max = WIN_W'(20'hFFFFB);
                w.start_repeat_min = WIN_W'(20'hFFFFC);
                w.start_arm_min = WIN_W'(20'hFFFFE);
                w.start_max = '1;
            end
            // One window inside the zero window; every start burst arms
            WIN_OVERLAP:
            begin
                w.zero_min = WIN_W'(500);
                w.zero_max = WIN_W'(3000);
                w.one_min = WIN_W'(2000);
                w.one_max = WIN_W'(2600);
                w.start_repeat_min = WIN_W'(7000);
                w.start_arm_min = '0;
                w.start_max = WIN_W'(15000);
            end
            // Inverted start and one windows: nothing can arm
            WIN_BROKEN:
            begin
                w.zero_min = WIN_W'(1000);
                w.zero_max = WIN_W'(1400);
                w.one_min = WIN_W'(2600);
                w.one_max = WIN_W'(2000);
                w.start_repeat_min = WIN_W'(15000);
                w.start_arm_min = '0;
                w.start_max = WIN_W'(7000);
            end
            default:
            begin
                w.start_repeat_min = START_REPEAT_MIN_RST;
                w.start_max = START_MAX_RST;
                w.start_arm_min = START_ARM_MIN_RST;
                w.one_min = ONE_MIN_RST;
                w.one_max = ONE_MAX_RST;
                w.zero_min = ZERO_MIN_RST;
                w.zero_max = ZERO_MAX_RST;
            end
        endcase
        return w;
    endfunction

    // Ordered, disjoint windows at random positions
    function automatic x10rf_win_t sane_windows();
        x10rf_win_t w;
        w.zero_min = WIN_W'($urandom_range(2000, 0));
        w.zero_max = w.zero_min + WIN_W'($urandom_range(600, 0));
        w.one_min = w.zero_max + WIN_W'($urandom_range(1000, 1));
        w.one_max = w.one_min + WIN_W'($urandom_range(1000, 0));
        w.start_repeat_min = w.one_max + WIN_W'($urandom_range(6000, 1));
        w.start_max = w.start_repeat_min + WIN_W'($urandom_range(12000, 0));
        w.start_arm_min = w.start_repeat_min +
                          WIN_W'($urandom_range(32'(w.start_max - w.start_repeat_min), 0));
        return w;
    endfunction

    // Random interval inside a window, biased to its ends
    function automatic logic [TIME_W-1:0] pick_span(input logic [WIN_W-1:0] lo,
                                                     input logic [WIN_W-1:0] hi);
        int roll;
        roll = $urandom_range(99);
        if (lo > hi)
        begin
            return $urandom;
        end
        if (roll < 15)
        begin
            return TIME_W'(lo);
        end
        if (roll < 30)
        begin
            return TIME_W'(hi);
        end
        return $urandom_range(32'(hi), 32'(lo));
    endfunction

    task automatic add_edge(input logic [TIME_W-1:0] gap);
        gen_stamp = gen_stamp + gap;
        edge_queue.push_back(gen_stamp);
        queued_count++;
    endtask

    // Queue an arming start burst, sometimes after a short one, and 32 bit intervals carrying a chosen code
    task automatic queue_frame(output int used);
        logic [BYTE_W-1:0] v0, v1, v2, v3;
        logic [WORD_W-1:0] bits;
        logic [WIN_W-1:0]  arm_lo;
        int                shape;
        int                bad_at;
        shape = $urandom_range(99);
        v0 = BYTE_W'($urandom);
        v1 = BYTE_W'($urandom);
        v2 = BYTE_W'($urandom);
        v3 = BYTE_W'($urandom);
        if (shape < 40)
        begin
            v1 = v1 & ~v0;
            v3 = v3 & ~v2;
        end
        else if (shape < 80)
        begin
            v1 = v0 ^ SEC_LOW_XOR;
            v3 = v2 ^ SEC_HIGH_XOR;
        end
        else if (shape < 90)
        begin
            // Passes both checks: standard must win
            v0 = v0 & SEC_LOW_XOR;
            v1 = v0 ^ SEC_LOW_XOR;
            v3 = ~v2;
        end
        bits = {mirror_byte(v3), mirror_byte(v2), mirror_byte(v1), mirror_byte(v0)};
        used = 1;
        // Sometimes lead with a short repeat burst that does not arm
        if ($urandom_range(99) < 20 && win_model.start_arm_min > win_model.start_repeat_min)
        begin
            add_edge(pick_span(win_model.start_repeat_min, win_model.start_arm_min - 1'b1));
            used++;
        end
        arm_lo = (win_model.start_arm_min > win_model.start_repeat_min) ?
                 win_model.start_arm_min : win_model.start_repeat_min;
        add_edge(pick_span(arm_lo, win_model.start_max));
        bad_at = ($urandom_range(99) < 8) ? int'($urandom_range(31)) : -1;
        for (int k = 0; k < FRAME_BITS; k++)
        begin
            if (k == bad_at)
            begin
                add_edge($urandom_range(20000));
            end
            else if (bits[k])
            begin
                add_edge(pick_span(win_model.one_min, win_model.one_max));
            end
            else
            begin
                add_edge(pick_span(win_model.zero_min, win_model.zero_max));
            end
            used++;
        end
    endtask

    task automatic queue_noise();
        logic [WIN_W-1:0] anchor;
        case ($urandom_range(3))
            0: add_edge($urandom);
            1: add_edge($urandom_range(20000));
            2:
            begin
                // Land one below, on, or one above a window edge
                anchor = WIN_W'(win_model >> (WIN_W * int'($urandom_range(REG_COUNT - 1))));
                add_edge(TIME_W'(anchor) + $urandom_range(2) - 32'd1);
            end
            default: add_edge('0);
        endcase
    endtask

    task automatic fill(input int budget);
        int got;
        int used;
        got = 0;
        while (got < budget)
        begin
            if ($urandom_range(99) < 12)
            begin
                queue_noise();
            end
            else
            begin
                queue_frame(used);
                got += used;
            end
        end
        frame_items += got;
    endtask

    // Wait for every queued edge to be taken and every code word to come back
    task automatic wait_idle();
        while (accepted_count != queued_count || pending_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input x10rf_win_t w, input int idle_pct, input int stall,
                             input int budget);
        write_reg(REG_START_REPEAT_MIN, w.start_repeat_min);
        write_reg(REG_START_MAX, w.start_max);
        write_reg(REG_START_ARM_MIN, w.start_arm_min);
        write_reg(REG_ONE_MIN, w.one_min);
        write_reg(REG_ONE_MAX, w.one_max);
        write_reg(REG_ZERO_MIN, w.zero_min);
        write_reg(REG_ZERO_MAX, w.zero_max);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        // Hold the sender mid-phase until all code words are back
        fill(budget / 2);
        wait_idle();
        fill(budget - budget / 2);
        wait_idle();
    endtask

    initial
    begin
        int extra;
        win_model = preset_windows(WIN_RESET);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed edges under the reset windows
        send_idle_pct = 0;
        stall_pct = 0;
        add_edge(TIME_W'(START_ARM_MIN_RST));      // first edge, measured from zero, arms
        add_edge(TIME_W'(ONE_MIN_RST));
        add_edge(TIME_W'(ONE_MAX_RST));
        add_edge(TIME_W'(ZERO_MIN_RST));
        add_edge(TIME_W'(ZERO_MAX_RST));
        add_edge(TIME_W'(ZERO_MAX_RST) + 32'd1);   // between windows: abort
        add_edge(TIME_W'(START_MAX_RST));          // longest start burst arms
        add_edge(TIME_W'(START_REPEAT_MIN_RST));   // short burst keeps position
        add_edge(TIME_W'(ONE_MIN_RST));
        add_edge(TIME_W'(START_ARM_MIN_RST) - 32'd1);
        add_edge(TIME_W'(ONE_MAX_RST) + 32'd1);    // abort
        add_edge(TIME_W'(START_REPEAT_MIN_RST) - 32'd1);
        add_edge(TIME_W'(START_MAX_RST) + 32'd1);
        add_edge(TIME_W'(ZERO_MIN_RST) - 32'd1);
        add_edge('1 - gen_stamp);                  // stamp at all ones
        add_edge(TIME_W'(START_ARM_MIN_RST));      // interval across the wrap
        add_edge('0);                              // same stamp twice
        add_edge(TIME_W'(ZERO_MIN_RST));
        add_edge('0 - gen_stamp);                  // stamp at zero
        add_edge($urandom);
        fill(130);
        wait_idle();

        run_phase(sane_windows(), 56, 0, 130);
        run_phase(preset_windows(WIN_LOW_EDGE), 0, 56, 100);
        run_phase(preset_windows(WIN_HIGH_EDGE), 20, 20, 100);
        run_phase(preset_windows(WIN_OVERLAP), 0, 0, 130);
        run_phase(preset_windows(WIN_BROKEN), 56, 0, 60);
        run_phase(sane_windows(), 0, 56, 130);
        run_phase(preset_windows(WIN_RESET), 20, 20, 130);

        // Keep going until enough edges and code words have passed
        extra = 0;
        while ((frame_items < 1050 || result_count < 40) && extra < 20)
        begin
            case (extra % 4)
                0:       run_phase(sane_windows(), 0, 0, 130);
                1:       run_phase(sane_windows(), 56, 0, 130);
                2:       run_phase(sane_windows(), 0, 56, 130);
                default: run_phase(sane_windows(), 20, 20, 130);
            endcase
            extra++;
        end

        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/x10rf_pkg.sv
hdl/x10rf_regs.sv
hdl/x10_rf_pulse_interval_decoder_core.sv
hdl/x10rf_checker.sv
tb/sv/x10_rf_pulse_interval_decoder_core_tb.sv
